@@ hdl/ccbd_pkg.sv @@
// Shared types, constants and codes for the circular crop bilinear downscale core.
package ccbd_pkg;

  localparam int unsigned MaxCropDef  = 512;
  localparam int unsigned MaxWidthDef = 4096;
  localparam int unsigned MaxOutDef   = 512;

  localparam logic [12:0] FrameWidthRst = 13'd800;
  localparam logic [11:0] CropLeftRst   = 12'd122;
  localparam logic [11:0] CropTopRst    = 12'd44;
  localparam logic [8:0]  RadiusRst     = 9'd240;
  localparam logic [9:0]  OutSizeRst    = 10'd240;

  localparam logic [11:0] FrameRowMax = 12'd4095;

  // Mapping numerator width and the long division that also yields the Q0.16 fraction.
  localparam int unsigned NxW   = 21;
  localparam int unsigned DivW  = NxW + 16;
  localparam int unsigned CntW  = $clog2(DivW);
  localparam int unsigned RemW  = 12;
  localparam logic [23:0] White = 24'hFFFFFF;

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH = 3'd0,
    CFG_CROP_LEFT   = 3'd1,
    CFG_CROP_TOP    = 3'd2,
    CFG_RADIUS      = 3'd3,
    CFG_OUT_SIZE    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    K_STORE = 2'd0,
    K_PASS  = 2'd1,
    K_BLEND = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    F_WAIT = 2'd0,
    F_LOAD = 2'd1,
    F_GEOM = 2'd2,
    F_PROC = 2'd3
  } front_st_e;

  typedef enum logic [2:0] {
    B_IDLE = 3'd0,
    B_EXEC = 3'd1,
    B_H    = 3'd2,
    B_V    = 3'd3,
    B_OUT  = 3'd4
  } back_st_e;

  // Saturated geometry derived from the configuration registers.
  typedef struct packed {
    logic [12:0] fw;
    logic [11:0] left;
    logic [11:0] top;
    logic [10:0] s;
    logic [10:0] m;
    logic [9:0]  half;
  } geo_t;

  // One classified pixel handed from the front to the back.
  typedef struct packed {
    kind_e       kind;
    logic [23:0] pix;
    logic [9:0]  col;
    logic [8:0]  ocol;
    logic [8:0]  orow;
    logic        last;
    logic [15:0] wx;
    logic [15:0] wy;
  } ent_t;

endpackage

@@ hdl/ccbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ccbd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hdl/ccbd_fifo.sv @@
// Short queue between the classifying front and the interpolating back.
module ccbd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [AW:0]      cnt_q, cnt_d;

  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop_i) begin
      rp_d = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

@@ hdl/ccbd_front.sv @@
// Front: frame position tracking, circle mask, output target mapping and classification.
module ccbd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ccbd_pkg::geo_t geo_i,
  input  logic           cfg_wr_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [23:0]    pix_i,
  input  logic           sof_i,
  output logic           push_o,
  output ccbd_pkg::ent_t ent_o,
  input  logic           full_i
);
  import ccbd_pkg::*;

  front_st_e st_q, st_d;

  logic [11:0]     fcol_q, fcol_d, frow_q, frow_d;
  logic [8:0]      ocol_q, ocol_d, orow_q, orow_d;
  logic            done_q, done_d, gok_q, gok_d, pend_q, pend_d;
  logic [23:0]     pix_q, pix_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] dvx_q, dvx_d, dvy_q, dvy_d, qx_q, qx_d, qy_q, qy_d;
  logic [RemW-1:0] remx_q, remx_d, remy_q, remy_d;

  logic              accept, in_win, pass, match, fw_wrap, geom_done;
  logic [11:0]       dcol, drow;
  logic [9:0]        c, r;
  logic signed [10:0] dx, dy;
  logic signed [21:0] dx2, dy2;
  logic [22:0]       rsq;
  logic [19:0]       hh;
  logic [23:0]       pix_m;
  logic [RemW-1:0]   den;
  logic [RemW:0]     tx, ty;
  logic              gex, gey;
  logic [NxW-1:0]    nx, ny;
  logic [NxW:0]      x0p1, y0p1;
  logic [9:0]        ocol_n, orow_n;

  always_comb begin
    accept    = (st_q == F_WAIT) && gok_q && in_valid_i;
    dcol      = fcol_q - geo_i.left;
    drow      = frow_q - geo_i.top;
    in_win    = (fcol_q >= geo_i.left) && (dcol < 12'(geo_i.s)) &&
                (frow_q >= geo_i.top) && (drow < 12'(geo_i.s));
    c         = dcol[9:0];
    r         = drow[9:0];
    dx        = $signed({1'b0, c}) - $signed({1'b0, geo_i.half});
    dy        = $signed({1'b0, r}) - $signed({1'b0, geo_i.half});
    dx2       = dx * dx;
    dy2       = dy * dy;
    rsq       = {1'b0, dx2[21:0]} + {1'b0, dy2[21:0]};
    hh        = geo_i.half * geo_i.half;
    pix_m     = (rsq > 23'(hh)) ? White : pix_q;
    pass      = geo_i.m == geo_i.s;
    x0p1      = (NxW+1)'(qx_q[DivW-1:16]) + 1'b1;
    y0p1      = (NxW+1)'(qy_q[DivW-1:16]) + 1'b1;
    match     = !done_q && (11'(ocol_q) < geo_i.m) && (11'(orow_q) < geo_i.m) &&
                ((NxW+1)'(c) == x0p1) && ((NxW+1)'(r) == y0p1);
    fw_wrap   = (13'(fcol_q) + 13'd1) >= geo_i.fw;
    ocol_n    = 10'(ocol_q) + 10'd1;
    orow_n    = 10'(orow_q) + 10'd1;
    // Restoring division of the numerator, extended by 16 fraction bits, by 2M.
    den       = {geo_i.m, 1'b0};
    tx        = {remx_q, dvx_q[DivW-1]};
    ty        = {remy_q, dvy_q[DivW-1]};
    gex       = tx >= {1'b0, den};
    gey       = ty >= {1'b0, den};
    nx        = NxW'(NxW'({ocol_q, 1'b1}) * NxW'(geo_i.s)) - NxW'(geo_i.m);
    ny        = NxW'(NxW'({orow_q, 1'b1}) * NxW'(geo_i.s)) - NxW'(geo_i.m);
    geom_done = cnt_q == CntW'(DivW - 1);
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      F_WAIT: begin
        if (!gok_q) begin
          st_d = F_LOAD;
        end else if (accept) begin
          st_d = sof_i ? F_LOAD : F_PROC;
        end
      end
      F_LOAD: st_d = F_GEOM;
      F_GEOM: begin
        if (geom_done) begin
          st_d = pend_q ? F_PROC : F_WAIT;
        end
      end
      F_PROC: begin
        if (!(in_win && full_i)) begin
          st_d = F_WAIT;
        end
      end
      default: st_d = F_WAIT;
    endcase
    if (cfg_wr_i && (st_q == F_LOAD || st_q == F_GEOM)) begin
      st_d = F_LOAD;
    end
  end

  // Datapath and outputs.
  always_comb begin
    fcol_d = fcol_q;
    frow_d = frow_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    done_d = done_q;
    gok_d  = gok_q;
    pend_d = pend_q;
    pix_d  = pix_q;
    cnt_d  = cnt_q;
    dvx_d  = dvx_q;
    dvy_d  = dvy_q;
    qx_d   = qx_q;
    qy_d   = qy_q;
    remx_d = remx_q;
    remy_d = remy_q;
    push_o = 1'b0;
    in_ready_o = (st_q == F_WAIT) && gok_q;

    ent_o.kind = pass ? K_PASS : (match ? K_BLEND : K_STORE);
    ent_o.pix  = pix_m;
    ent_o.col  = c;
    ent_o.ocol = pass ? c[8:0] : ocol_q;
    ent_o.orow = pass ? r[8:0] : orow_q;
    ent_o.last = pass ? ((11'(c) == geo_i.s - 11'd1) && (11'(r) == geo_i.s - 11'd1))
                      : ((11'(ocol_q) == geo_i.m - 11'd1) &&
                         (11'(orow_q) == geo_i.m - 11'd1));
    ent_o.wx   = qx_q[15:0];
    ent_o.wy   = qy_q[15:0];

    case (st_q)
      F_WAIT: begin
        if (accept) begin
          pix_d  = pix_i;
          pend_d = 1'b1;
          if (sof_i) begin
            fcol_d = '0;
            frow_d = '0;
            ocol_d = '0;
            orow_d = '0;
            done_d = 1'b0;
            gok_d  = 1'b0;
          end
        end
      end
      F_LOAD: begin
        dvx_d  = {nx, 16'd0};
        dvy_d  = {ny, 16'd0};
        qx_d   = '0;
        qy_d   = '0;
        remx_d = '0;
        remy_d = '0;
        cnt_d  = '0;
      end
      F_GEOM: begin
        dvx_d  = dvx_q << 1;
        dvy_d  = dvy_q << 1;
        qx_d   = {qx_q[DivW-2:0], gex};
        qy_d   = {qy_q[DivW-2:0], gey};
        remx_d = gex ? RemW'(tx - {1'b0, den}) : tx[RemW-1:0];
        remy_d = gey ? RemW'(ty - {1'b0, den}) : ty[RemW-1:0];
        cnt_d  = cnt_q + 1'b1;
        if (geom_done) begin
          gok_d = 1'b1;
        end
      end
      F_PROC: begin
        if (!(in_win && full_i)) begin
          push_o = in_win;
          pend_d = 1'b0;
          if (in_win && !pass && match) begin
            gok_d = 1'b0;
            if (11'(ocol_n) >= geo_i.m) begin
              ocol_d = '0;
              if (11'(orow_n) >= geo_i.m) begin
                orow_d = '0;
                done_d = 1'b1;
              end else begin
                orow_d = orow_n[8:0];
              end
            end else begin
              ocol_d = ocol_n[8:0];
            end
          end
          if (fw_wrap) begin
            fcol_d = '0;
            if (frow_q < FrameRowMax) begin
              frow_d = frow_q + 12'd1;
            end
          end else begin
            fcol_d = fcol_q + 12'd1;
          end
        end
      end
      default: ;
    endcase
    if (cfg_wr_i) begin
      gok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_WAIT;
      fcol_q <= '0;
      frow_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      done_q <= 1'b0;
      gok_q  <= 1'b0;
      pend_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      st_q   <= st_d;
      fcol_q <= fcol_d;
      frow_q <= frow_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
      done_q <= done_d;
      gok_q  <= gok_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= pix_d;
    dvx_q  <= dvx_d;
    dvy_q  <= dvy_d;
    qx_q   <= qx_d;
    qy_q   <= qy_d;
    remx_q <= remx_d;
    remy_q <= remy_d;
  end

endmodule

@@ hdl/ccbd_back.sv @@
// Back: line store, neighbor tracking, bilinear blend and the output register.
module ccbd_back #(
  parameter int unsigned MAX_CROP = ccbd_pkg::MaxCropDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  output logic           pop_o,
  input  ccbd_pkg::ent_t ent_i,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [47:0]    m_axis_tdata,  // out_red, out_green, out_blue, out_col, out_row
  output logic           m_axis_tlast   // last_of_image
);
  import ccbd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_CROP);

  back_st_e st_q, st_d;
  ent_t        ent_q, ent_d;
  logic [23:0] abl_q, abl_d, left_q, left_d;
  logic [23:0] p00_q, p00_d, p01_q, p01_d, p10_q, p10_d, p11_q, p11_d;
  logic [1:0]  ch_q, ch_d;
  logic [23:0] h_q, h_d, l_q, l_d;
  logic [7:0]  rr_q, rr_d, rg_q, rg_d, rb_q, rb_d;
  logic        mv_q, mv_d;
  logic [47:0] md_q, md_d;
  logic        ml_q, ml_d;

  logic        ram_we, ram_re;
  logic [23:0] above;
  logic [7:0]  a00, a01, a10, a11;
  logic [16:0] w0x, w0y;
  logic [40:0] v;
  logic [7:0]  vbyte;

  ccbd_ram #(
    .WIDTH(24),
    .DEPTH(MAX_CROP)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ent_q.col[AW-1:0]),
    .wdata_i(ent_q.pix),
    .re_i   (ram_re),
    .raddr_i(ent_i.col[AW-1:0]),
    .rdata_o(above)
  );

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;
  assign m_axis_tlast  = ml_q;

  always_comb begin
    case (ch_q)
      2'd0: begin
        a00 = p00_q[23:16]; a01 = p01_q[23:16]; a10 = p10_q[23:16]; a11 = p11_q[23:16];
      end
      2'd1: begin
        a00 = p00_q[15:8]; a01 = p01_q[15:8]; a10 = p10_q[15:8]; a11 = p11_q[15:8];
      end
      default: begin
        a00 = p00_q[7:0]; a01 = p01_q[7:0]; a10 = p10_q[7:0]; a11 = p11_q[7:0];
      end
    endcase
    w0x   = 17'h10000 - 17'(ent_q.wx);
    w0y   = 17'h10000 - 17'(ent_q.wy);
    v     = 41'(w0y * h_q) + 41'(ent_q.wy * l_q) + 41'h0080000000;
    vbyte = v[39:32];
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      B_IDLE: if (!empty_i) st_d = B_EXEC;
      B_EXEC: begin
        case (ent_q.kind)
          K_PASS:  st_d = B_OUT;
          K_BLEND: st_d = B_H;
          default: st_d = B_IDLE;
        endcase
      end
      B_H: st_d = B_V;
      B_V: st_d = (ch_q == 2'd2) ? B_OUT : B_H;
      B_OUT: if (!mv_q || m_axis_tready) st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    ent_d  = ent_q;
    abl_d  = abl_q;
    left_d = left_q;
    p00_d  = p00_q;
    p01_d  = p01_q;
    p10_d  = p10_q;
    p11_d  = p11_q;
    ch_d   = ch_q;
    h_d    = h_q;
    l_d    = l_q;
    rr_d   = rr_q;
    rg_d   = rg_q;
    rb_d   = rb_q;
    md_d   = md_q;
    ml_d   = ml_q;
    mv_d   = mv_q && !m_axis_tready;
    pop_o  = 1'b0;
    ram_re = 1'b0;
    ram_we = 1'b0;
    case (st_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          ram_re = 1'b1;
          ent_d  = ent_i;
        end
      end
      B_EXEC: begin
        // The word read is the pixel one row above; the one before it is above-left.
        ram_we = 1'b1;
        p00_d  = abl_q;
        p01_d  = above;
        p10_d  = left_q;
        p11_d  = ent_q.pix;
        abl_d  = above;
        left_d = ent_q.pix;
        ch_d   = 2'd0;
        rr_d   = ent_q.pix[23:16];
        rg_d   = ent_q.pix[15:8];
        rb_d   = ent_q.pix[7:0];
      end
      B_H: begin
        h_d = 24'(w0x * a00) + 24'(ent_q.wx * a01);
        l_d = 24'(w0x * a10) + 24'(ent_q.wx * a11);
      end
      B_V: begin
        case (ch_q)
          2'd0:    rr_d = vbyte;
          2'd1:    rg_d = vbyte;
          default: rb_d = vbyte;
        endcase
        ch_d = ch_q + 2'd1;
      end
      B_OUT: begin
        if (!mv_q || m_axis_tready) begin
          mv_d = 1'b1;
          md_d = {6'd0, ent_q.orow, ent_q.ocol, rb_q, rg_q, rr_q};
          ml_d = ent_q.last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= B_IDLE;
      mv_q   <= 1'b0;
      abl_q  <= '0;
      left_q <= '0;
      ch_q   <= '0;
    end else begin
      st_q   <= st_d;
      mv_q   <= mv_d;
      abl_q  <= abl_d;
      left_q <= left_d;
      ch_q   <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    p00_q <= p00_d;
    p01_q <= p01_d;
    p10_q <= p10_d;
    p11_q <= p11_d;
    h_q   <= h_d;
    l_q   <= l_d;
    rr_q  <= rr_d;
    rg_q  <= rg_d;
    rb_q  <= rb_d;
    md_q  <= md_d;
    ml_q  <= ml_d;
  end

endmodule

@@ hdl/circular_crop_bilinear_downscale_core.sv @@
// Top level of the circular crop and bilinear downscale core.
// Pixels enter in raster order; the square window of side 2*radius at (crop_left, crop_top)
// is masked to a white-cornered circle and shrunk to out_size square by bilinear blending,
// or passed through when out_size reaches the window side. The front takes a pixel and
// classifies it before taking another; start_of_frame, a configuration write and each
// downscaled output send it through a load state and 37 steps of a radix-2 long division
// mapping the next output position to its source pixels and Q0.16 weights. The back takes
// one entry at a time: a stored pixel in its execute state, a passed one then in its output
// state, a blended one first in a horizontal and a vertical step per channel; a four-entry
// queue lets the two sides stall independently, and the output register holds a result while
// the back keeps storing pixels. The line store is one RAM of MAX_CROP words.
module circular_crop_bilinear_downscale_core #(
  parameter int unsigned MAX_CROP  = ccbd_pkg::MaxCropDef,
  parameter int unsigned MAX_WIDTH = ccbd_pkg::MaxWidthDef,
  parameter int unsigned MAX_OUT   = ccbd_pkg::MaxOutDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red, green, blue
  input  logic        s_axis_tuser,  // start_of_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // out_red, out_green, out_blue, out_col, out_row
  output logic        m_axis_tlast   // last_of_image
);
  import ccbd_pkg::*;

  logic [12:0] fw_q;
  logic [11:0] left_q, top_q;
  logic [8:0]  rad_q;
  logic [9:0]  osz_q;
  geo_t        geo;
  logic [9:0]  rsat;
  logic [10:0] msat;
  logic [12:0] fwsat;

  logic push, pop, full, empty;
  ent_t ent_w, ent_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FrameWidthRst;
      left_q <= CropLeftRst;
      top_q  <= CropTopRst;
      rad_q  <= RadiusRst;
      osz_q  <= OutSizeRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FRAME_WIDTH: fw_q   <= cfg_wdata_i;
        CFG_CROP_LEFT:   left_q <= cfg_wdata_i[11:0];
        CFG_CROP_TOP:    top_q  <= cfg_wdata_i[11:0];
        CFG_RADIUS:      rad_q  <= cfg_wdata_i[8:0];
        CFG_OUT_SIZE:    osz_q  <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rsat = (rad_q == '0) ? 10'd1 : 10'(rad_q);
    if (rsat > 10'(MAX_CROP / 2)) rsat = 10'(MAX_CROP / 2);
    msat = (osz_q == '0) ? 11'd1 : 11'(osz_q);
    if (msat > {rsat, 1'b0}) msat = {rsat, 1'b0};
    if (msat > 11'(MAX_OUT)) msat = 11'(MAX_OUT);
    fwsat = (fw_q == '0) ? 13'd1 : fw_q;
    if (14'(fwsat) > 14'(MAX_WIDTH)) fwsat = 13'(MAX_WIDTH);
    geo.fw   = fwsat;
    geo.left = left_q;
    geo.top  = top_q;
    geo.s    = {rsat, 1'b0};
    geo.m    = msat;
    geo.half = rsat;
  end

  ccbd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .geo_i     (geo),
    .cfg_wr_i  (cfg_we_i),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .pix_i     ({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
    .sof_i     (s_axis_tuser),
    .push_o    (push),
    .ent_o     (ent_w),
    .full_i    (full)
  );

  ccbd_fifo #(
    .WIDTH($bits(ent_t)),
    .DEPTH(4)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(ent_w),
    .pop_i  (pop),
    .rdata_o(ent_r),
    .full_o (full),
    .empty_o(empty)
  );

  ccbd_back #(
    .MAX_CROP(MAX_CROP)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .pop_o        (pop),
    .ent_i        (ent_r),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

@@ hdl/ccbd_checker.sv @@
// Port-level checks for the circular crop bilinear downscale core, bound to the top level.
module ccbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        cfg_we_i,
  input logic        s_axis_tready
);

  // A stalled result request stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output request dropped while stalled");

  // The final pixel of an image sits on the diagonal corner.
  a_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[32:24] == m_axis_tdata[41:33])
    else $error("last pixel not on the corner");

  // The padding above the row field is always zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:42] == 6'd0)
    else $error("nonzero padding in output data");

  // After a configuration write the mapping is recomputed before input is taken again.
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input taken with stale mapping");

endmodule

bind circular_crop_bilinear_downscale_core ccbd_checker u_ccbd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .cfg_we_i     (cfg_we_i),
  .s_axis_tready(s_axis_tready)
);

@@ tb/circular_crop_bilinear_downscale_core_checker.sv @@
`timescale 1ns / 1ps
// Checker for the circular crop bilinear downscale core: predicts results and compares them.
module circular_crop_bilinear_downscale_core_checker
  import ccbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          pending_o,
  output int          fail_o
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] col;
    logic [8:0] row;
    logic       last;
  } out_pix_t;

  out_pix_t    expected_pixels[$];

  logic [12:0] reg_fw;
  logic [11:0] reg_left;
  logic [11:0] reg_top;
  logic [8:0]  reg_radius;
  logic [9:0]  reg_out;

  logic [23:0] row_above[MaxCropDef];
  logic [23:0] row_cur[MaxCropDef];
  logic [11:0] pos_col, pos_row;
  logic [8:0]  next_col, next_row;
  logic [23:0] prev_pix;
  logic        image_done;

  assign pending_o = expected_pixels.size();

  function automatic logic [7:0] mix_channel(logic [23:0] p00, logic [23:0] p01,
                                             logic [23:0] p10, logic [23:0] p11,
                                             longint unsigned wx, longint unsigned wy,
                                             int sh);
    longint unsigned h, l, v;
    h = (65536 - wx) * ((p00 >> sh) & 255) + wx * ((p01 >> sh) & 255);
    l = (65536 - wx) * ((p10 >> sh) & 255) + wx * ((p11 >> sh) & 255);
    v = (65536 - wy) * h + wy * l;
    return 8'((v + 64'h8000_0000) >> 32);
  endfunction

  task automatic predict_pixel(logic [23:0] in_pix, logic sof);
    int unsigned s, m, half, fw, c, r, den, nx, ny, x0, y0;
    int dx, dy;
    logic [23:0] pix, above, left_nb, p00;
    longint unsigned wx, wy;
    out_pix_t o;
    // Stored pixels keep red in the top byte.
    pix = {in_pix[7:0], in_pix[15:8], in_pix[23:16]};
    s = (reg_radius == 0) ? 1 : reg_radius;
    if (s > MaxCropDef / 2) s = MaxCropDef / 2;
    s = 2 * s;
    m = (reg_out == 0) ? 1 : reg_out;
    if (m > s) m = s;
    if (m > MaxOutDef) m = MaxOutDef;
    half = s / 2;
    fw = (reg_fw == 0) ? 1 : reg_fw;
    if (fw > MaxWidthDef) fw = MaxWidthDef;
    if (sof) begin
      pos_col = 0; pos_row = 0; next_col = 0; next_row = 0; image_done = 0;
    end
    if (pos_col >= reg_left && pos_col - reg_left < s &&
        pos_row >= reg_top && pos_row - reg_top < s) begin
      c = pos_col - reg_left;
      r = pos_row - reg_top;
      dx = int'(c) - int'(half);
      dy = int'(r) - int'(half);
      if (dx * dx + dy * dy > int'(half * half)) pix = White;
      above = row_cur[c];
      row_above[c] = above;
      row_cur[c] = pix;
      left_nb = prev_pix;
      prev_pix = pix;
      if (m == s) begin
        o = '{pix[23:16], pix[15:8], pix[7:0], 9'(c), 9'(r),
              (c == s - 1 && r == s - 1)};
        expected_pixels.push_back(o);
      end else if (!image_done && next_col < m && next_row < m) begin
        den = 2 * m;
        nx = (2 * next_col + 1) * s - m;
        ny = (2 * next_row + 1) * s - m;
        x0 = nx / den;
        y0 = ny / den;
        if (c == x0 + 1 && r == y0 + 1) begin
          wx = (longint'(nx % den) << 16) / den;
          wy = (longint'(ny % den) << 16) / den;
          p00 = row_above[x0];
          o.red   = mix_channel(p00, above, left_nb, pix, wx, wy, 16);
          o.green = mix_channel(p00, above, left_nb, pix, wx, wy, 8);
          o.blue  = mix_channel(p00, above, left_nb, pix, wx, wy, 0);
          o.col   = next_col;
          o.row   = next_row;
          o.last  = (next_col == m - 1 && next_row == m - 1);
          expected_pixels.push_back(o);
          next_col++;
          if (next_col >= m) begin
            next_col = 0;
            next_row++;
            if (next_row >= m) begin
              next_row = 0;
              image_done = 1;
            end
          end
        end
      end
    end
    if (pos_col + 1 >= fw) begin
      pos_col = 0;
      if (pos_row < FrameRowMax) pos_row++;
    end else begin
      pos_col++;
    end
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_pix_t e;
    if (!rst_ni) begin
      fail_o = 0;
      reg_fw = FrameWidthRst; reg_left = CropLeftRst; reg_top = CropTopRst;
      reg_radius = RadiusRst; reg_out = OutSizeRst;
      for (int i = 0; i < MaxCropDef; i++) begin
        row_above[i] = '0;
        row_cur[i] = '0;
      end
      pos_col = 0; pos_row = 0; next_col = 0; next_row = 0;
      prev_pix = '0; image_done = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_FRAME_WIDTH: reg_fw = cfg_wdata_i;
          CFG_CROP_LEFT:   reg_left = cfg_wdata_i[11:0];
          CFG_CROP_TOP:    reg_top = cfg_wdata_i[11:0];
          CFG_RADIUS:      reg_radius = cfg_wdata_i[8:0];
          CFG_OUT_SIZE:    reg_out = cfg_wdata_i[9:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected output pixel: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
          fail_o++;
        end else begin
          e = expected_pixels.pop_front();
          check_field("out_red", e.red, m_axis_tdata[7:0]);
          check_field("out_green", e.green, m_axis_tdata[15:8]);
          check_field("out_blue", e.blue, m_axis_tdata[23:16]);
          check_field("out_col", e.col, m_axis_tdata[32:24]);
          check_field("out_row", e.row, m_axis_tdata[41:33]);
          check_field("last_of_image", e.last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_pixel(s_axis_tdata, s_axis_tuser);
    end
  end

endmodule

@@ tb/circular_crop_bilinear_downscale_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, pixel stimulus, output stalls and the verdict.
module circular_crop_bilinear_downscale_core_tb;
  import ccbd_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned SettleCycles = 300;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_addr_i = '0;
  logic [12:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          pending, fails;
  int unsigned cycles = 0;
  int          burst_left = 0;
  int          pixels_sent = 0;

  always #2 clk_i = ~clk_i;

  circular_crop_bilinear_downscale_core u_dut (.*);

  circular_crop_bilinear_downscale_core_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .pending_o(pending), .fail_o(fails)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver switches between free flow, light and heavy stalling.
  int ready_pct = 100;
  always @(negedge clk_i) begin
    if (cycles % 97 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 75;
        2: ready_pct = 40;
        default: ready_pct = 10;
      endcase
    end
    m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= 13'(value);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain_results();
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_geometry(int unsigned fw, int unsigned left, int unsigned top,
                              int unsigned rad, int unsigned osz);
    drain_results();
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_CROP_LEFT, left);
    write_reg(CFG_CROP_TOP, top);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_OUT_SIZE, osz);
  endtask

  // Valid stays high within a burst; a gap only falls between bursts.
  task automatic send_pixel(logic [23:0] data, logic sof);
    if (burst_left == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tdata <= data;
    s_axis_tuser <= sof;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [23:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // One frame of npix pixels; noise occasionally restarts the frame early.
  task automatic send_frame(int unsigned npix, bit noisy);
    for (int unsigned i = 0; i < npix; i++) begin
      send_pixel(pick_pixel(), (i == 0) || (noisy && $urandom_range(0, 60) == 0));
    end
    s_axis_tvalid <= 0;
    burst_left = 0;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned fw, rad, s, left, top;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;

    // Directed: a small downscale, pass-through, zeroed registers and extremes.
    set_geometry(6, 1, 1, 2, 3);
    send_frame(6 * 5, 0);
    set_geometry(5, 0, 0, 2, 4);
    send_frame(5 * 4, 0);
    set_geometry(0, 0, 0, 0, 0);
    send_frame(4, 0);
    set_geometry(3, 0, 4095, 1, 1);
    send_frame(9, 0);
    set_geometry(8191, 0, 0, 1, 1);
    send_frame(4, 0);
    set_geometry(512, 0, 0, 511, 1023);
    send_frame(64, 0);
    set_geometry(4096, 4095, 1, 256, 512);
    send_frame(10, 0);

    // Random geometries with several frames each.
    while (pixels_sent < 600) begin
      fw  = $urandom_range(1, 14);
      rad = $urandom_range(1, 5);
      s   = 2 * rad;
      left = (fw > s && $urandom_range(0, 7) != 0) ? $urandom_range(0, fw - s)
                                                    : $urandom_range(0, 15);
      top = $urandom_range(0, 3);
      set_geometry(fw, left, top, rad, $urandom_range(0, s + 2));
      repeat ($urandom_range(1, 3)) begin
        send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(1, fw * (top + s))
                                               : fw * (top + s),
                   $urandom_range(0, 4) == 0);
      end
    end

    drain_results();
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
